// File: sv/mfwc_pkg.sv
`default_nettype none
package mfwc_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] MODE_TX_BYTE  = 4'd0;
    localparam logic [3:0] MODE_TX_CRC   = 4'd1;
    localparam logic [3:0] MODE_DELAY    = 4'd2;
    localparam logic [3:0] MODE_WAIT_RX  = 4'd3;
    localparam logic [3:0] MODE_RX_BYTE  = 4'd4;
    localparam logic [3:0] MODE_CRC_CHK  = 4'd5;
    localparam logic [3:0] MODE_DEC_DLY  = 4'd6;
    localparam logic [3:0] MODE_PUSH     = 4'd7;
    localparam logic [3:0] MODE_MATCH    = 4'd8;
    localparam logic [3:0] MODE_CLEAR    = 4'd9;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CRC_BAD    = 3'd1;
    localparam logic [2:0] ST_NOT_DELAY  = 3'd2;
    localparam logic [2:0] ST_Q_EMPTY    = 3'd3;
    localparam logic [2:0] ST_UNMATCHED  = 3'd4;
    localparam logic [2:0] ST_Q_FULL     = 3'd5;

    localparam logic [1:0] CFG_DELAY        = 2'd0;
    localparam logic [1:0] CFG_LONG_DELAY   = 2'd1;
    localparam logic [1:0] CFG_WAIT_RX      = 2'd2;
    localparam logic [1:0] CFG_WAIT_LONG_RX = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [11:0] SHORT_MAX     = 12'hFFF;
    localparam logic [7:0]  ADDR_LAST_OK  = 8'd247;
    localparam logic [7:0]  ADDR_BCAST    = 8'd255;
    localparam logic [21:0] US_PER_MS     = 22'd1000;
    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
    localparam logic [31:0] DIV_MAGIC     = 32'd274877907;
    localparam int          DIV_SHIFT     = 38;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/modbus_fifo_word_codec_crc.sv
// Modbus FIFO word codec with running CRC-16 and command/response queue.
// Input channel (i_valid/o_ready) carries mode, value, address and function
// code; output channel (o_valid/i_ready) carries one result item per input
// item, two for a CRC send (low byte then high byte, o_last on the second).
// Unused modes (10..15) are consumed without any result.
// An accepted item is registered in the input stage, and its result is loaded
// into the output register once that register is free, from where the receiver
// takes it.
// The input register and the output register run as a two-stage
// pipeline: one item per cycle is taken while the receiver keeps up, and a
// CRC send holds the input stage until its second result is loaded.
// The queue of 16 commanded pairs is a register file read at the head pointer.
// When the receiver stalls, the output register holds its item and the input
// stage fills and then drops o_ready until the result is taken.
// Reset (synchronous, active low) empties both stages and the queue, sets
// the CRC to 0xFFFF and the four word codes to 1, 2, 3 and 4. Queue entries
// are not cleared. Configuration writes take effect at once.
`default_nettype none
module modbus_fifo_word_codec_crc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_mode,
    input  wire logic [31:0] i_value,
    input  wire logic [7:0]  i_address,
    input  wire logic [7:0]  i_function_code,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_word,
    output logic [21:0]      o_delay_value,
    output logic [2:0]       o_status,
    output logic [15:0]      o_calc_crc,
    output logic [7:0]       o_expected_address,
    output logic [7:0]       o_expected_function,
    output logic             o_last
);
    import mfwc_pkg::*;

    logic [3:0]  r_delay_code, r_long_delay_code, r_wait_rx_code, r_wait_long_rx_code;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_queue [QUEUE_DEPTH];
    logic [QW-1:0] r_head, r_tail, n_head, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic        r_a_valid, r_phase, n_phase;
    logic [3:0]  r_a_mode;
    logic [31:0] r_a_value;
    logic [7:0]  r_a_addr, r_a_func;

    logic        r_o_valid;
    logic [15:0] r_o_word, n_o_word;
    logic [21:0] r_o_dly, n_o_dly;
    logic [2:0]  r_o_status, n_o_status;
    logic [15:0] r_o_crc;
    logic [7:0]  r_o_ea, n_o_ea, r_o_ef, n_o_ef;
    logic        r_o_last, n_o_last;

    logic        out_free, mode_ok, emit, a_done, q_write;
    logic [63:0] div_prod;
    logic [11:0] long_cnt;
    logic [3:0]  sel_short, sel_long, nib;
    logic [15:0] time_wd, head_pair;
    logic        addr_ok, q_full, q_empty;

    function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(p + 1'b1);
    endfunction

    always_comb begin
        out_free = !r_o_valid || i_ready;
        mode_ok  = (r_a_mode <= MODE_CLEAR);
        emit     = r_a_valid && mode_ok && out_free;
        a_done   = r_a_valid && (!mode_ok ||
                   (out_free && ((r_a_mode != MODE_TX_CRC) || r_phase)));
        o_ready  = !r_a_valid || a_done;
    end

    // delay / wait word
    always_comb begin
        div_prod  = {32'd0, r_a_value} * {32'd0, DIV_MAGIC};
        long_cnt  = 12'(div_prod[DIV_SHIFT +: 12] + 12'd1);
        sel_short = (r_a_mode == MODE_DELAY) ? r_delay_code : r_wait_rx_code;
        sel_long  = (r_a_mode == MODE_DELAY) ? r_long_delay_code : r_wait_long_rx_code;
        if (|r_a_value[31:12]) begin
            time_wd = {sel_long, long_cnt};
        end else begin
            time_wd = {sel_short, r_a_value[11:0] & SHORT_MAX};
        end
        nib       = r_a_value[15:12];
        head_pair = r_queue[r_head];
        addr_ok   = ((r_a_addr != 8'd0) && (r_a_addr <= ADDR_LAST_OK)) ||
                    (r_a_addr == ADDR_BCAST);
        q_full    = (r_count >= CW'(QUEUE_DEPTH));
        q_empty   = (r_count == '0);
    end

    always_comb begin
        n_o_word   = '0;
        n_o_dly    = '0;
        n_o_status = ST_OK;
        n_o_ea     = '0;
        n_o_ef     = '0;
        n_o_last   = 1'b1;
        n_crc      = r_crc;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_phase    = r_phase;
        q_write    = 1'b0;
        unique case (r_a_mode)
            MODE_TX_BYTE, MODE_RX_BYTE: begin
                n_o_word = {8'd0, r_a_value[7:0]};
                n_crc    = crc_byte(r_crc, r_a_value[7:0]);
            end
            MODE_TX_CRC: begin
                if (!r_phase) begin
                    n_o_word = {8'd0, r_crc[7:0]};
                    n_o_last = 1'b0;
                    n_phase  = 1'b1;
                end else begin
                    n_o_word = {8'd0, r_crc[15:8]};
                    n_phase  = 1'b0;
                    n_crc    = CRC_INIT;
                end
            end
            MODE_DELAY, MODE_WAIT_RX: begin
                n_o_word = time_wd;
            end
            MODE_CRC_CHK: begin
                n_o_status = (r_a_value[15:0] != r_crc) ? ST_CRC_BAD : ST_OK;
                n_crc      = CRC_INIT;
            end
            MODE_DEC_DLY: begin
                priority if (nib == r_delay_code) begin
                    n_o_dly = {10'd0, r_a_value[11:0]};
                end else if (nib == r_long_delay_code) begin
                    n_o_dly = 22'({10'd0, r_a_value[11:0]} * US_PER_MS);
                end else begin
                    n_o_status = ST_NOT_DELAY;
                end
            end
            MODE_PUSH: begin
                if (addr_ok) begin
                    if (q_full) begin
                        n_o_status = ST_Q_FULL;
                    end else begin
                        q_write = 1'b1;
                        n_tail  = ptr_inc(r_tail);
                        n_count = CW'(r_count + 1'b1);
                    end
                end
            end
            MODE_MATCH: begin
                if (q_empty) begin
                    n_o_status = ST_Q_EMPTY;
                end else begin
                    n_head  = ptr_inc(r_head);
                    n_count = CW'(r_count - 1'b1);
                    if (head_pair != {r_a_addr, r_a_func}) begin
                        n_o_status = ST_UNMATCHED;
                        n_o_ea     = head_pair[15:8];
                        n_o_ef     = head_pair[7:0];
                    end
                end
            end
            MODE_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
                n_crc   = CRC_INIT;
            end
            default: begin
                n_o_last = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_code        <= 4'd1;
            r_long_delay_code   <= 4'd2;
            r_wait_rx_code      <= 4'd3;
            r_wait_long_rx_code <= 4'd4;
            r_crc     <= CRC_INIT;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_phase   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DELAY:        r_delay_code        <= i_cfg_data;
                    CFG_LONG_DELAY:   r_long_delay_code   <= i_cfg_data;
                    CFG_WAIT_RX:      r_wait_rx_code      <= i_cfg_data;
                    CFG_WAIT_LONG_RX: r_wait_long_rx_code <= i_cfg_data;
                    default:          r_delay_code        <= r_delay_code;
                endcase
            end
            if (emit) begin
                r_crc   <= n_crc;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_phase <= n_phase;
            end
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (out_free) begin
                r_o_valid <= emit;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_mode  <= i_mode;
            r_a_value <= i_value;
            r_a_addr  <= i_address;
            r_a_func  <= i_function_code;
        end
        if (emit) begin
            r_o_word   <= n_o_word;
            r_o_dly    <= n_o_dly;
            r_o_status <= n_o_status;
            r_o_crc    <= r_crc;
            r_o_ea     <= n_o_ea;
            r_o_ef     <= n_o_ef;
            r_o_last   <= n_o_last;
        end
        if (emit && q_write) begin
            r_queue[r_tail] <= {r_a_addr, r_a_func};
        end
    end

    assign o_valid             = r_o_valid;
    assign o_word              = r_o_word;
    assign o_delay_value       = r_o_dly;
    assign o_status            = r_o_status;
    assign o_calc_crc          = r_o_crc;
    assign o_expected_address  = r_o_ea;
    assign o_expected_function = r_o_ef;
    assign o_last              = r_o_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with unequal pointers");

    a_crc_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> (o_valid && o_last))
        else $error("second CRC byte missing");

    a_phase_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_a_valid && (r_a_mode == MODE_TX_CRC)))
        else $error("CRC phase set without CRC send item");
`endif
endmodule
`default_nettype wire

// File: tb/sv/modbus_codec_checker.sv
module modbus_codec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [3:0]  i_mode,
    input  logic [31:0] i_value,
    input  logic [7:0]  i_address,
    input  logic [7:0]  i_function_code,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_word,
    input  logic [21:0] i_delay_value,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_calc_crc,
    input  logic [7:0]  i_expected_address,
    input  logic [7:0]  i_expected_function,
    input  logic        i_last,
    input  logic        i_end_check,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    import mfwc_pkg::*;

    typedef struct packed {
        logic [15:0] word;
        logic [21:0] delay_value;
        logic [2:0]  status;
        logic [15:0] calc_crc;
        logic [7:0]  exp_addr;
        logic [7:0]  exp_func;
        logic        last;
    } t_codec_result;

    t_codec_result awaited_results [$];
    logic [15:0]   crc_acc;
    logic [15:0]   pair_store [QUEUE_DEPTH];
    logic [QW-1:0] q_head;
    logic [QW-1:0] q_tail;
    int            q_count;
    logic [3:0]    code_delay;
    logic [3:0]    code_long_delay;
    logic [3:0]    code_wait_rx;
    logic [3:0]    code_wait_long_rx;
    int            fail_count = 0;
    int            results_seen = 0;
    bit            leftovers_checked = 1'b0;

    function automatic logic [15:0] crc16_shift_in(input logic [15:0] acc,
                                                   input logic [7:0] data);
        logic [15:0] r;
        r = acc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (r[0])
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            else
                r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    // Values past 12 bits switch to the millisecond code, rounded up by one.
    function automatic logic [15:0] timing_word(input logic [31:0] us,
                                                input logic [3:0] short_code,
                                                input logic [3:0] long_code);
        logic [31:0] ms;
        if (us > 32'h0000_0FFF) begin
            ms = us / 32'd1000 + 32'd1;
            return {long_code, ms[11:0]};
        end
        return {short_code, us[11:0]};
    endfunction

    function automatic void log_failure(input string what, input t_codec_result want,
                                        input t_codec_result got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, what);
            $display("  expected word=%h delay=%0d status=%0d crc=%h ea=%h ef=%h last=%b",
                     want.word, want.delay_value, want.status, want.calc_crc,
                     want.exp_addr, want.exp_func, want.last);
            $display("  actual   word=%h delay=%0d status=%0d crc=%h ea=%h ef=%h last=%b",
                     got.word, got.delay_value, got.status, got.calc_crc,
                     got.exp_addr, got.exp_func, got.last);
        end
    endfunction

    function automatic void predict_codec_item(input logic [3:0] mode,
                                               input logic [31:0] value,
                                               input logic [7:0] addr,
                                               input logic [7:0] func);
        t_codec_result r;
        logic [15:0]   pair;
        r = '0;
        r.calc_crc = crc_acc;
        r.last = 1'b1;
        case (mode)
            MODE_TX_BYTE, MODE_RX_BYTE: begin
                r.word = {8'h00, value[7:0]};
                crc_acc = crc16_shift_in(crc_acc, value[7:0]);
            end
            MODE_TX_CRC: begin
                r.word = {8'h00, crc_acc[7:0]};
                r.last = 1'b0;
                awaited_results.insert(awaited_results.size(), r);
                r.word = {8'h00, crc_acc[15:8]};
                r.last = 1'b1;
                crc_acc = CRC_INIT;
            end
            MODE_DELAY:   r.word = timing_word(value, code_delay, code_long_delay);
            MODE_WAIT_RX: r.word = timing_word(value, code_wait_rx, code_wait_long_rx);
            MODE_CRC_CHK: begin
                if (value[15:0] != crc_acc)
                    r.status = ST_CRC_BAD;
                crc_acc = CRC_INIT;
            end
            MODE_DEC_DLY: begin
                // short code wins when both codes are equal
                if (value[15:12] == code_delay)
                    r.delay_value = {10'd0, value[11:0]};
                else if (value[15:12] == code_long_delay)
                    r.delay_value = {10'd0, value[11:0]} * US_PER_MS;
                else
                    r.status = ST_NOT_DELAY;
            end
            MODE_PUSH: begin
                if ((addr != 8'd0 && addr <= ADDR_LAST_OK) || addr == ADDR_BCAST) begin
                    if (q_count == QUEUE_DEPTH) begin
                        r.status = ST_Q_FULL;
                    end else begin
                        pair_store[q_tail] = {addr, func};
                        q_tail = q_tail + 1'b1;
                        q_count++;
                    end
                end
            end
            MODE_MATCH: begin
                if (q_count == 0) begin
                    r.status = ST_Q_EMPTY;
                end else begin
                    pair = pair_store[q_head];
                    q_head = q_head + 1'b1;
                    q_count--;
                    if (pair != {addr, func}) begin
                        r.status = ST_UNMATCHED;
                        r.exp_addr = pair[15:8];
                        r.exp_func = pair[7:0];
                    end
                end
            end
            MODE_CLEAR: begin
                q_head = '0;
                q_tail = '0;
                q_count = 0;
                crc_acc = CRC_INIT;
            end
            default: return;
        endcase
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    always @(posedge i_clk) begin : watch
        t_codec_result got;
        t_codec_result want;
        if (!i_rst_n) begin
            awaited_results.delete();
            crc_acc = CRC_INIT;
            q_head = '0;
            q_tail = '0;
            q_count = 0;
            code_delay = 4'd1;
            code_long_delay = 4'd2;
            code_wait_rx = 4'd3;
            code_wait_long_rx = 4'd4;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DELAY:        code_delay = i_cfg_data;
                    CFG_LONG_DELAY:   code_long_delay = i_cfg_data;
                    CFG_WAIT_RX:      code_wait_rx = i_cfg_data;
                    CFG_WAIT_LONG_RX: code_wait_long_rx = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_word, i_delay_value, i_status, i_calc_crc,
                       i_expected_address, i_expected_function, i_last};
                results_seen++;
                if (awaited_results.size() == 0) begin
                    log_failure("result with nothing awaited", '0, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got != want)
                        log_failure("result mismatch", want, got);
                end
            end
            if (i_in_valid && i_in_ready)
                predict_codec_item(i_mode, i_value, i_address, i_function_code);
            if (i_end_check && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (awaited_results.size() != 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0d results never arrived", awaited_results.size());
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending <= awaited_results.size();
        o_results_seen <= results_seen;
    end

endmodule

// File: tb/sv/testbench.sv
module testbench;
    import mfwc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 260;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_DELAY;
    logic [3:0]  cfg_data = 4'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  mode = MODE_TX_BYTE;
    logic [31:0] value = 32'd0;
    logic [7:0]  address = 8'd0;
    logic [7:0]  function_code = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] word;
    logic [21:0] delay_value;
    logic [2:0]  status;
    logic [15:0] calc_crc;
    logic [7:0]  expected_address;
    logic [7:0]  expected_function;
    logic        last;
    logic        end_check = 1'b0;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          items_sent = 0;
    int          stall_cycles = 0;
    logic [3:0]  cur_delay_code = 4'd1;
    logic [3:0]  cur_long_code = 4'd2;

    modbus_fifo_word_codec_crc dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_valid             (in_valid),
        .o_ready             (in_ready),
        .i_mode              (mode),
        .i_value             (value),
        .i_address           (address),
        .i_function_code     (function_code),
        .o_valid             (out_valid),
        .i_ready             (out_ready),
        .o_word              (word),
        .o_delay_value       (delay_value),
        .o_status            (status),
        .o_calc_crc          (calc_crc),
        .o_expected_address  (expected_address),
        .o_expected_function (expected_function),
        .o_last              (last)
    );

    modbus_codec_checker codec_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_mode              (mode),
        .i_value             (value),
        .i_address           (address),
        .i_function_code     (function_code),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_word              (word),
        .i_delay_value       (delay_value),
        .i_status            (status),
        .i_calc_crc          (calc_crc),
        .i_expected_address  (expected_address),
        .i_expected_function (expected_function),
        .i_last              (last),
        .i_end_check         (end_check),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_results_seen      (results_seen)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Any handshake on either channel counts as progress.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("modbus_fifo_word_codec_crc verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus-side CRC, used only to build frames with a correct trailer.
    function automatic logic [15:0] next_frame_crc(input logic [15:0] acc,
                                                   input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
        return c;
    endfunction

    function automatic logic [31:0] pick_us();
        int unsigned sel;
        case ($urandom_range(5))
            0: return $urandom_range(4095);
            1: return $urandom_range(5000, 4090);
            2: return $urandom_range(4097999, 4094000);
            3: return $urandom;
            4: return $urandom_range(32'h00FF_FFFF);
            default: begin
                sel = $urandom_range(3);
                return (sel == 0) ? 32'h0 : (sel == 1) ? 32'h0FFF :
                       (sel == 2) ? 32'h1000 : 32'hFFFF_FFFF;
            end
        endcase
    endfunction

    task automatic send_item(input logic [3:0] m, input logic [31:0] v,
                             input logic [7:0] a, input logic [7:0] f);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        value <= v;
        address <= a;
        function_code <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender until every awaited result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [15:0] code_sets [6];
        logic [15:0] frame_crc;
        logic [15:0] sent_pairs [$];
        logic [15:0] pair;
        logic [31:0] rv;
        logic [7:0]  a;
        int          phase_end;
        int          burst;
        int          n;
        int          stored;
        bit          paused;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every mode, default codes
        send_item(MODE_TX_BYTE, 32'h0000_0000, 8'h00, 8'h00);
        send_item(MODE_TX_BYTE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_item(MODE_TX_CRC, 32'h0, 8'h00, 8'h00);
        send_item(MODE_DELAY, 32'h0000_0000, 8'h00, 8'h00);
        send_item(MODE_DELAY, 32'h0000_1000, 8'h00, 8'h00);
        send_item(MODE_DELAY, 32'hFFFF_FFFF, 8'h00, 8'h00);
        send_item(MODE_WAIT_RX, 32'h0000_0FFF, 8'h00, 8'h00);
        send_item(MODE_WAIT_RX, 32'h0000_1000, 8'h00, 8'h00);
        send_item(MODE_CLEAR, 32'h0, 8'h00, 8'h00);
        // read-holding-register request, trailer 84 0A
        send_item(MODE_RX_BYTE, 32'h01, 8'h00, 8'h00);
        send_item(MODE_RX_BYTE, 32'h03, 8'h00, 8'h00);
        send_item(MODE_RX_BYTE, 32'h00, 8'h00, 8'h00);
        send_item(MODE_RX_BYTE, 32'h00, 8'h00, 8'h00);
        send_item(MODE_RX_BYTE, 32'h00, 8'h00, 8'h00);
        send_item(MODE_RX_BYTE, 32'h01, 8'h00, 8'h00);
        send_item(MODE_CRC_CHK, 32'h0000_0A84, 8'h00, 8'h00);
        send_item(MODE_CRC_CHK, 32'h0000_1234, 8'h00, 8'h00);
        send_item(MODE_DEC_DLY, 32'h0000_1ABC, 8'h00, 8'h00);
        send_item(MODE_DEC_DLY, 32'h0000_2FFF, 8'h00, 8'h00);
        send_item(MODE_DEC_DLY, 32'h0000_F000, 8'h00, 8'h00);
        send_item(MODE_PUSH, 32'h0, 8'd0, 8'h03);
        send_item(MODE_PUSH, 32'h0, 8'd248, 8'h03);
        send_item(MODE_PUSH, 32'h0, 8'd1, 8'h03);
        send_item(MODE_PUSH, 32'h0, 8'd255, 8'hFF);
        send_item(MODE_MATCH, 32'h0, 8'd1, 8'h03);
        send_item(MODE_MATCH, 32'h0, 8'd255, 8'h00);
        send_item(MODE_MATCH, 32'h0, 8'd1, 8'h03);
        send_item(4'hF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);

        rv = $urandom;
        code_sets[0] = 16'h0F0F;
        code_sets[1] = 16'hF0F0;
        code_sets[2] = 16'h7799;
        code_sets[3] = rv[15:0];
        code_sets[4] = rv[31:16];
        code_sets[5] = 16'h1234;

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 72 : 0;
            recv_stall_pct <= (ph < 2) ? 72 : (ph < 4) ? 13 : 0;
            drain_results();
            cfg_we <= 1'b1;
            cfg_idx <= CFG_DELAY;
            cfg_data <= code_sets[ph][15:12];
            @(posedge clk);
            cfg_idx <= CFG_LONG_DELAY;
            cfg_data <= code_sets[ph][11:8];
            @(posedge clk);
            cfg_idx <= CFG_WAIT_RX;
            cfg_data <= code_sets[ph][7:4];
            @(posedge clk);
            cfg_idx <= CFG_WAIT_LONG_RX;
            cfg_data <= code_sets[ph][3:0];
            @(posedge clk);
            cfg_we <= 1'b0;
            cur_delay_code = code_sets[ph][15:12];
            cur_long_code = code_sets[ph][11:8];

            phase_end = items_sent + PHASE_ITEMS;
            paused = 1'b0;
            while (items_sent < phase_end) begin
                if (!paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                burst = $urandom_range(99);
                if (burst < 20) begin
                    // outgoing frame, sometimes led by a delay word
                    if ($urandom_range(2) == 0)
                        send_item(MODE_DELAY, pick_us(), 8'h00, 8'h00);
                    n = $urandom_range(8, 1);
                    repeat (n) begin
                        rv = $urandom;
                        send_item(MODE_TX_BYTE, rv, rv[15:8], rv[23:16]);
                    end
                    rv = $urandom;
                    send_item(MODE_TX_CRC, rv, rv[15:8], rv[23:16]);
                end else if (burst < 40) begin
                    // incoming frame; a quarter carry a damaged trailer
                    send_item(MODE_CLEAR, $urandom, 8'h00, 8'h00);
                    frame_crc = CRC_INIT;
                    n = $urandom_range(8, 1);
                    repeat (n) begin
                        rv = $urandom;
                        frame_crc = next_frame_crc(frame_crc, rv[7:0]);
                        send_item(MODE_RX_BYTE, rv, rv[15:8], rv[23:16]);
                    end
                    rv = $urandom;
                    rv[15:0] = frame_crc;
                    if (rv[31:30] == 2'b00)
                        rv[15:0] = frame_crc ^ (16'h0001 << rv[19:16]);
                    send_item(MODE_CRC_CHK, rv, rv[27:20], rv[29:22]);
                end else if (burst < 60) begin
                    // fill the command queue, then answer it in order
                    send_item(MODE_CLEAR, $urandom, 8'h00, 8'h00);
                    sent_pairs.delete();
                    n = $urandom_range(20, 1);
                    repeat (n) begin
                        rv = $urandom;
                        if (rv[31:29] == 3'b000) begin
                            a = (rv[18:16] == 3'd7) ? 8'd0 : 8'd248 + {5'd0, rv[18:16]};
                        end else begin
                            a = (rv[7:0] == 8'd0 || rv[7:0] > ADDR_LAST_OK) ?
                                ADDR_BCAST : rv[7:0];
                            if (sent_pairs.size() < QUEUE_DEPTH)
                                sent_pairs.insert(sent_pairs.size(), {a, rv[15:8]});
                        end
                        send_item(MODE_PUSH, rv, a, rv[15:8]);
                    end
                    stored = sent_pairs.size();
                    repeat (stored + $urandom_range(1)) begin
                        rv = $urandom;
                        pair = (sent_pairs.size() != 0) ? sent_pairs.pop_front() : rv[15:0];
                        if (rv[31:29] == 3'b000)
                            pair = pair ^ (16'h0001 << rv[19:16]);
                        send_item(MODE_MATCH, rv, pair[15:8], pair[7:0]);
                    end
                end else if (burst < 75) begin
                    n = $urandom_range(4, 1);
                    repeat (n) begin
                        rv = $urandom;
                        send_item(rv[0] ? MODE_WAIT_RX : MODE_DELAY, pick_us(),
                                  rv[15:8], rv[23:16]);
                    end
                end else if (burst < 88) begin
                    rv = $urandom;
                    case ($urandom_range(2))
                        0: rv[15:12] = cur_delay_code;
                        1: rv[15:12] = cur_long_code;
                        default: ;
                    endcase
                    send_item(MODE_DEC_DLY, rv, rv[23:16], rv[31:24]);
                end else begin
                    rv = $urandom;
                    send_item(rv[3:0], $urandom, rv[15:8], rv[23:16]);
                end
            end
        end

        drain_results();
        end_check <= 1'b1;
        repeat (3) @(posedge clk);
        $display("Run covered %0d input items and %0d checked results over six code settings,",
                 items_sent, results_seen);
        $display("with sender and receiver gaps in both orders and a gap-free stretch.");
        if (fail_count == 0)
            $display("modbus_fifo_word_codec_crc verification clean");
        else
            $display("modbus_fifo_word_codec_crc verification failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/mfwc_pkg.sv
sv/modbus_fifo_word_codec_crc.sv
tb/sv/modbus_codec_checker.sv
tb/sv/testbench.sv
